// ----- src/dqom_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dqom_pkg;

	localparam int DAY_W     = 5;
	localparam int MON_W     = 4;
	localparam int VAL_W     = 32;
	localparam int ALW_W     = 16;
	localparam int DEN_W     = 5;
	localparam int DIV_STEPS = 32;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic [DAY_W-1:0] DAY_ONE  = 5'd1;
	localparam logic [DAY_W-1:0] CLR_NONE = 5'd31;
	localparam logic [DAY_W-1:0] DIM_28   = 5'd28;
	localparam logic [DAY_W-1:0] DIM_30   = 5'd30;
	localparam logic [DAY_W-1:0] DIM_31   = 5'd31;
	localparam logic [DEN_W-1:0] PRE_DEN  = 5'd30;

	localparam logic [MON_W-1:0] MON_JAN  = 4'd1;
	localparam logic [MON_W-1:0] MON_FEB  = 4'd2;
	localparam logic [MON_W-1:0] MON_APR  = 4'd4;
	localparam logic [MON_W-1:0] MON_JUN  = 4'd6;
	localparam logic [MON_W-1:0] MON_SEP  = 4'd9;
	localparam logic [MON_W-1:0] MON_NOV  = 4'd11;
	localparam logic [MON_W-1:0] MON_DEC  = 4'd12;
	localparam logic [MON_W-1:0] SLOT_DEC = 4'd11;

	localparam logic [ALW_W-1:0] ALW_MAX = 16'hFFFF;

	typedef struct packed {
		logic [DAY_W-1:0] last_day;
		logic [VAL_W-1:0] last_reading;
		logic [VAL_W-1:0] month_start;
		logic             warn;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [VAL_W-1:0] quo;
		logic [DEN_W-1:0] rmd;
	} div_rsp_t;

	typedef struct packed {
		logic             record_valid;
		logic [MON_W-1:0] month_slot;
		logic [VAL_W-1:0] month_amount;
		logic [DAY_W-1:0] day_slot;
		logic [VAL_W-1:0] day_amount;
		logic [DAY_W-1:0] clear_from;
		logic [ALW_W-1:0] day_allowance;
		logic             overrun;
		logic [VAL_W-1:0] overrun_usage;
	} res_t;

	localparam res_t RES_NONE = '{
		record_valid:  1'b0,
		month_slot:    '0,
		month_amount:  '0,
		day_slot:      '0,
		day_amount:    '0,
		clear_from:    CLR_NONE,
		day_allowance: '0,
		overrun:       1'b0,
		overrun_usage: '0
	};

endpackage
`default_nettype wire

// ----- src/dqom_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface dqom_in_if;
	import dqom_pkg::*;

	logic             valid;
	logic             ready;
	logic             meter_id;
	logic             meter_present;
	logic [DAY_W-1:0] day_of_month;
	logic [MON_W-1:0] month_number;
	logic [VAL_W-1:0] meter_reading;
	logic [VAL_W-1:0] month_limit;

	modport source (
		output valid, meter_id, meter_present, day_of_month, month_number,
			meter_reading, month_limit,
		input ready
	);
	modport sink (
		input valid, meter_id, meter_present, day_of_month, month_number,
			meter_reading, month_limit,
		output ready
	);
endinterface
`default_nettype wire

// ----- src/dqom_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface dqom_out_if;
	import dqom_pkg::*;

	logic             valid;
	logic             ready;
	logic             record_valid;
	logic [MON_W-1:0] month_slot;
	logic [VAL_W-1:0] month_amount;
	logic [DAY_W-1:0] day_slot;
	logic [VAL_W-1:0] day_amount;
	logic [DAY_W-1:0] clear_from;
	logic [ALW_W-1:0] day_allowance;
	logic             overrun;
	logic [VAL_W-1:0] overrun_usage;

	modport source (
		output valid, record_valid, month_slot, month_amount, day_slot, day_amount,
			clear_from, day_allowance, overrun, overrun_usage,
		input ready
	);
	modport sink (
		input valid, record_valid, month_slot, month_amount, day_slot, day_amount,
			clear_from, day_allowance, overrun, overrun_usage,
		output ready
	);
endinterface
`default_nettype wire

// ----- src/dqom_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dqom_div (
	input  logic                clk,
	input  logic                arst_n,
	input  dqom_pkg::div_req_t  req,
	output dqom_pkg::div_rsp_t  rsp
);
	import dqom_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] acc_q;
	logic [DEN_W-1:0] rmd_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// restoring step: one quotient bit a cycle
	assign trial = {rmd_q, acc_q[VAL_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			rmd_q  <= '0;
			den_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_STEPS);
			acc_q  <= req.num;
			rmd_q  <= '0;
			den_q  <= req.den;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
				acc_q <= {acc_q[VAL_W-2:0], fits};
				rmd_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && (cnt_q == '0);
	assign rsp.quo  = acc_q;
	assign rsp.rmd  = rmd_q;
endmodule
`default_nettype wire

// ----- src/dqom_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dqom_mem #(
	parameter int DEPTH = 2,
	parameter int AW    = 1
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output dqom_pkg::entry_t   rd_data,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  dqom_pkg::entry_t   wr_data
);
	import dqom_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ----- src/daily_quota_overrun_monitor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  side    handshake     word
// reading  sink    valid/ready   meter_id, meter_present, day_of_month, month_number,
//                                meter_reading, month_limit
// record   source  valid/ready   record_valid .. overrun_usage
//
// A reading of a started meter passes take, state lookup, the 32-step restoring divider
// for the allowance (state write-back when it is done) and output load.
// An absent meter skips lookup and divider; a first sample skips only the divider.
// Reset clears the started flags and the full-month flag; the state memory needs no clear.
// The output register holds a result while the next reading is taken and worked on.
module daily_quota_overrun_monitor #(
	parameter int METER_COUNT = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	dqom_in_if.sink    reading,
	dqom_out_if.source record
);
	import dqom_pkg::*;

	localparam int IDX_W = (METER_COUNT > 1) ? $clog2(METER_COUNT) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_DIV, ST_DONE} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       idx_q;
	logic [DAY_W-1:0]       day_q;
	logic [MON_W-1:0]       mon_q;
	logic [VAL_W-1:0]       rdg_q;
	logic [VAL_W-1:0]       lim_q;
	logic [METER_COUNT-1:0] started_q;
	logic                   fms_q;
	logic                   rnd_q;
	logic [DEN_W-1:0]       den_q;
	res_t                   res_q;
	res_t                   out_q;
	logic                   out_vld_q;

	logic             accept;
	logic             in_hit;
	logic [IDX_W-1:0] in_idx;
	logic [DAY_W-1:0] in_day;
	logic [MON_W-1:0] in_mon;

	entry_t           entry;
	entry_t           mem_wr;
	logic             mem_wr_en;
	logic             mem_rd_en;

	logic             first_day;
	logic             day_chg;
	logic             fms_now;
	logic [VAL_W-1:0] used;
	logic [VAL_W-1:0] rem;
	logic [DAY_W-1:0] dim;
	logic [DAY_W:0]   dim_p1;
	logic [DEN_W-1:0] dvs;
	logic [MON_W-1:0] mslot;
	logic [DAY_W-1:0] dslot;

	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic             round;
	logic [VAL_W:0]   sum;
	logic [ALW_W-1:0] allow;
	logic             over;
	logic             ovr;
	logic             out_load;

	assign reading.ready = (state_q == ST_IDLE);
	assign accept        = reading.valid && reading.ready;
	assign in_hit        = reading.meter_present && (32'(reading.meter_id) < 32'(METER_COUNT));
	assign in_idx        = IDX_W'(reading.meter_id);
	assign in_day        = (reading.day_of_month == '0) ? DAY_ONE : reading.day_of_month;

	always_comb begin
		if (reading.month_number == '0) begin
			in_mon = MON_JAN;
		end else if (reading.month_number > MON_DEC) begin
			in_mon = MON_DEC;
		end else begin
			in_mon = reading.month_number;
		end
	end

	assign mem_rd_en = accept && in_hit;

	dqom_mem #(
		.DEPTH (METER_COUNT),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (in_idx),
		.rd_data (entry),
		.wr_en   (mem_wr_en),
		.wr_addr (idx_q),
		.wr_data (mem_wr)
	);

	// lookup stage
	assign first_day = (day_q == DAY_ONE);
	assign day_chg   = (day_q != entry.last_day);
	assign fms_now   = fms_q || first_day;
	assign used      = first_day ? '0 : rdg_q - entry.month_start;
	assign rem       = (used > lim_q) ? '0 : lim_q - used;

	always_comb begin
		case (mon_q)
			MON_APR, MON_JUN, MON_SEP, MON_NOV: dim = DIM_30;
			MON_FEB:                            dim = DIM_28;
			default:                            dim = DIM_31;
		endcase
	end

	assign dim_p1 = {1'b0, dim} + (DAY_W + 1)'(1);
	assign dvs    = (dim_p1 > {1'b0, day_q}) ? DEN_W'(dim_p1 - {1'b0, day_q}) : DEN_W'(1);

	always_comb begin
		if (first_day) begin
			mslot = (mon_q == MON_JAN) ? SLOT_DEC : mon_q - MON_FEB;
		end else begin
			mslot = mon_q - MON_JAN;
		end
		if (day_chg) begin
			dslot = (entry.last_day == '0) ? '0 : entry.last_day - DAY_ONE;
		end else begin
			dslot = day_q - DAY_ONE;
		end
	end

	assign div_req.start = (state_q == ST_LOOK) && started_q[idx_q];
	assign div_req.num   = fms_now ? rem : lim_q;
	assign div_req.den   = fms_now ? dvs : PRE_DEN;

	dqom_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// allowance: quotient rounded half up once a month start is seen, truncated before, then saturated
	assign round = rnd_q && ({div_rsp.rmd, 1'b0} >= {1'b0, den_q});
	assign sum   = {1'b0, div_rsp.quo} + (VAL_W + 1)'(round);
	assign allow = (sum > (VAL_W + 1)'(ALW_MAX)) ? ALW_MAX : sum[ALW_W-1:0];
	assign over  = VAL_W'(allow) < res_q.day_amount;
	assign ovr   = over && entry.warn;

	assign out_load = (state_q == ST_DONE) && (!out_vld_q || record.ready);

	always_comb begin
		mem_wr_en = 1'b0;
		mem_wr    = entry;
		if (state_q == ST_LOOK && !started_q[idx_q]) begin
			mem_wr_en           = 1'b1;
			mem_wr.last_day     = day_q;
			mem_wr.last_reading = rdg_q;
			mem_wr.month_start  = rdg_q;
			mem_wr.warn         = 1'b0;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			mem_wr_en           = 1'b1;
			mem_wr.last_day     = day_q;
			mem_wr.last_reading = day_chg ? rdg_q : entry.last_reading;
			mem_wr.month_start  = first_day ? rdg_q : entry.month_start;
			mem_wr.warn         = over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			day_q     <= '0;
			mon_q     <= '0;
			rdg_q     <= '0;
			lim_q     <= '0;
			started_q <= '0;
			fms_q     <= 1'b0;
			rnd_q     <= 1'b0;
			den_q     <= '0;
			res_q     <= RES_NONE;
			out_q     <= RES_NONE;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (record.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= in_idx;
						day_q   <= in_day;
						mon_q   <= in_mon;
						rdg_q   <= reading.meter_reading;
						lim_q   <= reading.month_limit;
						res_q   <= RES_NONE;
						state_q <= in_hit ? ST_LOOK : ST_DONE;
					end
				end
				ST_LOOK: begin
					if (!started_q[idx_q]) begin
						started_q[idx_q] <= 1'b1;
						state_q          <= ST_DONE;
					end else begin
						fms_q              <= fms_now;
						rnd_q              <= fms_now;
						den_q              <= div_req.den;
						res_q.record_valid <= 1'b1;
						res_q.month_slot   <= mslot;
						res_q.month_amount <= rdg_q - entry.month_start;
						res_q.day_slot     <= dslot;
						res_q.day_amount   <= rdg_q - entry.last_reading;
						res_q.clear_from   <= first_day ? entry.last_day : CLR_NONE;
						state_q            <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						res_q.day_allowance <= allow;
						res_q.overrun       <= ovr;
						res_q.overrun_usage <= ovr ? res_q.day_amount : '0;
						state_q             <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign record.valid         = out_vld_q;
	assign record.record_valid  = out_q.record_valid;
	assign record.month_slot    = out_q.month_slot;
	assign record.month_amount  = out_q.month_amount;
	assign record.day_slot      = out_q.day_slot;
	assign record.day_amount    = out_q.day_amount;
	assign record.clear_from    = out_q.clear_from;
	assign record.day_allowance = out_q.day_allowance;
	assign record.overrun       = out_q.overrun;
	assign record.overrun_usage = out_q.overrun_usage;

	a_overrun_exceeds: assert property (@(posedge clk) disable iff (!arst_n)
		record.valid && record.overrun |->
			record.record_valid && (record.overrun_usage > VAL_W'(record.day_allowance)))
		else $error("overrun without usage above allowance");

	a_empty_record: assert property (@(posedge clk) disable iff (!arst_n)
		record.valid && !record.record_valid |->
			!record.overrun && (record.clear_from == CLR_NONE) && (record.day_allowance == '0))
		else $error("empty record carries data");

	a_no_wr_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> !accept)
		else $error("state write-back while a word is taken");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

endmodule
`default_nettype wire

// ----- test/daily_quota_overrun_monitor_test.sv -----
`timescale 1ns / 1ps
module daily_quota_overrun_monitor_test;
	import dqom_pkg::*;

	localparam int  RANDOM_READINGS = 1850;
	localparam int  CALM_TAIL       = 150;
	localparam int  CYCLE_LIMIT     = 1000000;
	localparam int  DRAIN_CYCLES    = 40;

	typedef struct packed {
		logic             id;
		logic             present;
		logic [DAY_W-1:0] day;
		logic [MON_W-1:0] month;
		logic [VAL_W-1:0] reading;
		logic [VAL_W-1:0] limit;
	} reading_t;

	class quota_scoreboard;
		bit               started[2];
		logic [DAY_W-1:0] last_day[2];
		logic [VAL_W-1:0] last_reading[2];
		logic [VAL_W-1:0] month_base[2];
		bit               warned[2];
		bit               month_seen;
		res_t             pending_records[$];
		int               mismatches;
		int               records_checked;
		int               overruns;
		int               clears;

		function logic [ALW_W-1:0] allowance_of(logic [MON_W-1:0] mon, logic [DAY_W-1:0] day,
				logic [VAL_W-1:0] lim, logic [VAL_W-1:0] used);
			longint unsigned rem, dv, q;
			int unsigned dim;
			if (!month_seen) begin
				q = 64'(lim) / 64'(PRE_DEN);
			end else begin
				rem = (used > lim) ? 64'd0 : {32'd0, lim - used};
				case (mon)
					MON_APR, MON_JUN, MON_SEP, MON_NOV: dim = 32'(DIM_30);
					MON_FEB: dim = 32'(DIM_28);
					default: dim = 32'(DIM_31);
				endcase
				dv = (dim + 1 > 32'(day)) ? 64'(dim + 1 - 32'(day)) : 64'd1;
				q = (2 * rem + dv) / (2 * dv);
			end
			return (q > ALW_MAX) ? ALW_MAX : q[ALW_W-1:0];
		endfunction

		function res_t meter_record(reading_t r);
			res_t             o;
			logic [DAY_W-1:0] d;
			logic [MON_W-1:0] m;
			logic [VAL_W-1:0] usage;
			int               i;
			o = RES_NONE;
			if (!r.present)
				return o;
			i = int'(r.id);
			d = (r.day == 0) ? DAY_ONE : r.day;
			m = (r.month == 0) ? MON_JAN : (r.month > MON_DEC) ? MON_DEC : r.month;
			if (!started[i]) begin
				started[i] = 1'b1;
				last_day[i] = d;
				last_reading[i] = r.reading;
				month_base[i] = r.reading;
				return o;
			end
			if (d == DAY_ONE) begin
				month_seen = 1'b1;
				o.clear_from = last_day[i];
				o.month_slot = (m == MON_JAN) ? SLOT_DEC : m - 4'd2;
				o.month_amount = r.reading - month_base[i];
				month_base[i] = r.reading;
			end else begin
				o.month_slot = m - 4'd1;
				o.month_amount = r.reading - month_base[i];
			end
			usage = r.reading - last_reading[i];
			if (d != last_day[i])
				o.day_slot = (last_day[i] == 0) ? '0 : last_day[i] - 5'd1;
			else
				o.day_slot = d - 5'd1;
			o.day_allowance = allowance_of(m, d, r.limit, r.reading - month_base[i]);
			if ({16'd0, o.day_allowance} < usage) begin
				if (warned[i]) begin
					o.overrun = 1'b1;
					o.overrun_usage = usage;
				end else begin
					warned[i] = 1'b1;
				end
			end else begin
				warned[i] = 1'b0;
			end
			if (d != last_day[i]) begin
				last_reading[i] = r.reading;
				last_day[i] = d;
			end
			o.record_valid = 1'b1;
			o.day_amount = usage;
			return o;
		endfunction

		function void note_reading(reading_t r);
			pending_records.push_back(meter_record(r));
		endfunction

		function void compare_field(string name, logic [VAL_W-1:0] e, logic [VAL_W-1:0] g);
			if (e !== g) begin
				mismatches++;
				$display("%0t: %s expected %0d, got %0d", $time, name, e, g);
			end
		endfunction

		function void check_record(res_t got);
			res_t e;
			if (pending_records.size() == 0) begin
				mismatches++;
				$display("%0t: record expected none, got %p", $time, got);
				return;
			end
			e = pending_records.pop_front();
			records_checked++;
			if (got.overrun)
				overruns++;
			if (got.clear_from != CLR_NONE)
				clears++;
			compare_field("record_valid", VAL_W'(e.record_valid), VAL_W'(got.record_valid));
			compare_field("month_slot", VAL_W'(e.month_slot), VAL_W'(got.month_slot));
			compare_field("month_amount", e.month_amount, got.month_amount);
			compare_field("day_slot", VAL_W'(e.day_slot), VAL_W'(got.day_slot));
			compare_field("day_amount", e.day_amount, got.day_amount);
			compare_field("clear_from", VAL_W'(e.clear_from), VAL_W'(got.clear_from));
			compare_field("day_allowance", VAL_W'(e.day_allowance), VAL_W'(got.day_allowance));
			compare_field("overrun", VAL_W'(e.overrun), VAL_W'(got.overrun));
			compare_field("overrun_usage", e.overrun_usage, got.overrun_usage);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   sent;
	int   cycles;

	quota_scoreboard sb = new;

	dqom_in_if  rd_if ();
	dqom_out_if rec_if ();

	daily_quota_overrun_monitor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.reading(rd_if),
		.record (rec_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d records outstanding", cycles,
				sb.pending_records.size());
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rec_if.valid && rec_if.ready)
				sb.check_record('{rec_if.record_valid, rec_if.month_slot, rec_if.month_amount,
					rec_if.day_slot, rec_if.day_amount, rec_if.clear_from,
					rec_if.day_allowance, rec_if.overrun, rec_if.overrun_usage});
			if (rd_if.valid && rd_if.ready)
				sb.note_reading('{rd_if.meter_id, rd_if.meter_present, rd_if.day_of_month,
					rd_if.month_number, rd_if.meter_reading, rd_if.month_limit});
		end
	end

	initial begin
		int n;
		rec_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				rec_if.ready = 1'b0;
				n = $urandom_range(1, 6);
			end else begin
				rec_if.ready = 1'b1;
				n = $urandom_range(1, 10);
			end
			repeat (n) @(negedge clk);
		end
	end

	// called at a falling edge, returns at a falling edge with valid left high
	task automatic send_reading(logic id, logic pres, logic [DAY_W-1:0] day,
			logic [MON_W-1:0] mon, logic [VAL_W-1:0] rdg, logic [VAL_W-1:0] lim);
		if (!calm && $urandom_range(0, 4) == 0) begin
			rd_if.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		rd_if.valid = 1'b1;
		rd_if.meter_id = id;
		rd_if.meter_present = pres;
		rd_if.day_of_month = day;
		rd_if.month_number = mon;
		rd_if.meter_reading = rdg;
		rd_if.month_limit = lim;
		@(posedge clk);
		while (!rd_if.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	function automatic int month_days(int m);
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return (m == 2) ? 28 : 31;
	endfunction

	function automatic logic [VAL_W-1:0] pick_cap();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom;
			2: return '1;
			default: return $urandom_range(1000, 1500000);
		endcase
	endfunction

	initial begin
		logic [VAL_W-1:0] meter_total[2];
		logic [VAL_W-1:0] month_cap[2];
		logic [VAL_W-1:0] step;
		int               cur_day, cur_mon, pick, m;
		logic             id;

		arst_n = 1'b0;
		rd_if.valid = 1'b0;
		rd_if.meter_id = 1'b0;
		rd_if.meter_present = 1'b0;
		rd_if.day_of_month = '0;
		rd_if.month_number = '0;
		rd_if.meter_reading = '0;
		rd_if.month_limit = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// absent meter, then first samples and the pre-month allowance
		send_reading(1'b1, 1'b0, 5'd31, 4'd15, '1, '1);
		send_reading(1'b0, 1'b1, 5'd5, 4'd13, 32'hFFFF_FFF0, '1);
		send_reading(1'b0, 1'b1, 5'd5, 4'd13, 32'h0000_0004, '1);
		send_reading(1'b0, 1'b1, 5'd5, 4'd15, 32'h0001_86A4, '0);
		send_reading(1'b0, 1'b1, 5'd6, 4'd12, 32'h0001_86D6, '0);
		send_reading(1'b1, 1'b1, 5'd31, 4'd2, 32'd0, 32'd1000);
		send_reading(1'b1, 1'b1, 5'd31, 4'd2, 32'd10, 32'd3000);
		// day zero and month zero: first of January, month rollover into the December slot
		send_reading(1'b0, 1'b1, 5'd0, 4'd0, 32'h0001_86DD, 32'd1000);
		send_reading(1'b0, 1'b1, 5'd1, 4'd1, 32'h0001_86E0, 32'd31000);
		// days past the month end, budget overspent, two in a row
		send_reading(1'b1, 1'b1, 5'd29, 4'd2, 32'd1000, 32'd2000);
		send_reading(1'b1, 1'b1, 5'd30, 4'd2, 32'd5000, 32'd2000);
		send_reading(1'b1, 1'b1, 5'd31, 4'd4, 32'd9000, 32'd2000);
		send_reading(1'b0, 1'b1, 5'd15, 4'd6, 32'h0001_86EA, '1);
		send_reading(1'b0, 1'b1, 5'd30, 4'd1, 32'h0001_86EB, 32'd7);
		for (m = 1; m <= 12; m++)
			send_reading(m[0], 1'b1, (m == 3) ? 5'd1 : 5'(10 + m), 4'(m),
				32'd9000 + 32'(m * 300), 32'(m * 40000));

		meter_total[0] = 32'hFFF0_0000;
		meter_total[1] = $urandom;
		month_cap[0] = pick_cap();
		month_cap[1] = pick_cap();
		cur_day = 1;
		cur_mon = 3;
		sent = 0;
		while (sent < RANDOM_READINGS) begin
			calm = (sent >= RANDOM_READINGS - CALM_TAIL);
			pick = $urandom_range(0, 99);
			id = 1'($urandom_range(0, 1));
			if (pick < 8) begin
				send_reading(id, 1'b0, 5'($urandom), 4'($urandom), $urandom, $urandom);
			end else if (pick < 16) begin
				send_reading(id, 1'b1, 5'($urandom), 4'($urandom), $urandom, $urandom);
			end else begin
				if ($urandom_range(0, 9) < 3) begin
					cur_day++;
					if (cur_day > 31 || (cur_day > month_days(cur_mon) &&
							$urandom_range(0, 7) != 0)) begin
						cur_day = 1;
						cur_mon = (cur_mon == 12) ? 1 : cur_mon + 1;
						month_cap[0] = pick_cap();
						month_cap[1] = pick_cap();
					end
				end
				step = month_cap[id] / 30;
				if ($urandom_range(0, 9) == 0)
					step = $urandom_range(0, 32'h00FF_FFFF);
				else
					step = $urandom_range(0, step);
				meter_total[id] += step;
				send_reading(id, 1'b1, 5'(cur_day), 4'(cur_mon), meter_total[id], month_cap[id]);
			end
		end
		rd_if.valid = 1'b0;

		while (sb.pending_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d readings sent, %0d records checked, %0d mismatches", sent,
			sb.records_checked, sb.mismatches);
		$display("%0d overruns flagged, %0d month rollovers with a daily clear", sb.overruns,
			sb.clears);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/dqom_pkg.sv
src/dqom_in_if.sv
src/dqom_out_if.sv
src/dqom_div.sv
src/dqom_mem.sv
src/daily_quota_overrun_monitor.sv
test/daily_quota_overrun_monitor_test.sv
